// ----- sv/phfh_pkg.sv -----
// phfh_pkg: shared constants and payload types of the pixel hit frame histogrammer
// no dependencies
`default_nettype none
package phfh_pkg;
	localparam int ROWS_DEF = 928;
	localparam int COLS_DEF = 960;
	localparam int MAP_W    = 20;
	localparam int EPOCH_W  = 8;
	localparam int CNT_W    = 16;

	localparam logic [31:0] HEADER_WORD = 32'haaaaaaaa;
	localparam logic [15:0] TAIL_WORD   = 16'h5678;

	localparam logic OP_STREAM = 1'b0;
	localparam logic OP_READ   = 1'b1;
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
		logic [9:0] read_row;
		logic [9:0] read_col;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [19:0] frame_number;
		logic [1:0]  latchup_flags;
		logic [7:0]  temperature;
		logic [1:0]  adc_channel;
		logic [9:0]  adc_value;
		logic        map_published;
		logic [15:0] pixel_count;
	} out_item_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [CNT_W-1:0]   count;
	} map_entry_t;
endpackage
`default_nettype wire

// ----- sv/pixel_hit_frame_histogrammer_top.sv -----
// a stream byte is taken in idle; a decoded hit runs read and wait for each pixel of its run;
// a pixel read in range runs read and wait, then emit; a frame end goes through emit to the
// output register, plus a clearing pass over the new accumulation bank when an epoch wraps;
// the map bank read-modify-write loop sets the pace: read, registered data, write. reset:
// asynchronous; a clearing pass over both banks follows, input stalled meanwhile, configuration taken as ever
`default_nettype none
module pixel_hit_frame_histogrammer_top
	import phfh_pkg::*;
#(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire in_item_t in_data,
	output logic       out_valid,
	input  wire        out_stall,
	output out_item_t  out_data,
	input  wire        cfg_we,
	input  wire [15:0] cfg_data
);
	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = $clog2(DEPTH);

	// one-hot sequencer
	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_RD   = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;

	// stream state
	logic [31:0] lfb_q;
	logic [2:0]  wi_q;
	logic        hbn_q;
	logic [7:0]  low_q;
	logic [15:0] prev_q;
	logic        tail_q;
	logic [9:0]  row_q;
	logic [MAP_W-1:0] row_base_q;
	logic [7:0]  stat_q [8];
	logic [3:0]  fill_q;
	logic [15:0] tally_q;
	logic [15:0] frames_q;

	// banks and epochs: the accumulation bank is acc_sel_q, the other is published
	logic               acc_sel_q;
	logic [EPOCH_W-1:0] ep_q [2];
	logic [1:0]         clr_mask_q;
	logic               clr_pend_q;
	logic [AW-1:0]      clr_addr_q;

	// run sequencing
	logic [AW-1:0] addr_q;
	logic [1:0]    run_q;
	logic          rmw_q;
	out_item_t     res_q;
	out_item_t     out_q;
	logic          out_valid_q;

	map_entry_t rd_data [2];
	map_entry_t wr_data;
	logic [1:0] bank_we;
	logic [AW-1:0] wr_addr;

	wire accept = in_valid && !in_stall;

	// next values of the stream on a streamed byte
	logic [31:0] lfb_n;
	logic [2:0]  wi_n;
	logic        hbn_n;
	logic [7:0]  low_n;
	logic [15:0] prev_n;
	logic        tail_n;
	logic [9:0]  row_n;
	logic [7:0]  stat_n [8];
	logic [3:0]  fill_n;
	logic        frame_end;
	logic        hit;
	logic [9:0]  hit_col;
	logic [1:0]  hit_code;
	logic [15:0] word;
	logic [15:0] tally_inc;
	logic        publish;
	logic [10:0] col_end;

	always_comb begin
		lfb_n     = {lfb_q[23:0], in_data.data_byte};
		wi_n      = wi_q;
		hbn_n     = hbn_q;
		low_n     = low_q;
		prev_n    = prev_q;
		tail_n    = tail_q;
		row_n     = row_q;
		fill_n    = fill_q;
		frame_end = 1'b0;
		hit       = 1'b0;
		word      = {in_data.data_byte, low_q};
		hit_col   = prev_q[11:2];
		hit_code  = prev_q[1:0];
		col_end   = 11'(hit_col) + 11'(hit_code);
		for (int k = 0; k < 8; k++) begin
			stat_n[k] = stat_q[k];
		end
		if (wi_q == 3'd0) begin
			if (lfb_n == HEADER_WORD) begin
				wi_n   = 3'd1;
				hbn_n  = 1'b0;
				fill_n = 4'd0;
			end
		end else begin
			if (fill_q < 4'd8) begin
				stat_n[fill_q[2:0]] = in_data.data_byte;
				fill_n = fill_q + 4'd1;
			end
			if (!hbn_q) begin
				low_n = in_data.data_byte;
				hbn_n = 1'b1;
			end else begin
				hbn_n  = 1'b0;
				prev_n = word;
				if (wi_q < 3'd7) begin
					wi_n = wi_q + 3'd1;
				end
				if (word == TAIL_WORD) begin
					if (!tail_q) begin
						tail_n = 1'b1;
					end else begin
						frame_end = 1'b1;
						wi_n      = 3'd0;
						tail_n    = 1'b0;
						fill_n    = 4'd8;
					end
				end else begin
					tail_n = 1'b0;
					if (wi_n == 3'd7) begin
						if (prev_q[12]) begin
							row_n = prev_q[11:2];
						end else if (col_end < 11'(COLS) && 32'(row_q) < 32'(ROWS)) begin
							hit = 1'b1;
						end
					end
				end
			end
		end
	end

	assign tally_inc = tally_q + 16'd1;
	assign publish   = (tally_inc == frames_q);

	// pixel read address, one constant multiply and an add
	logic [MAP_W-1:0] rd_base;
	logic [MAP_W-1:0] rd_lin;
	logic             rd_ok;
	assign rd_base = MAP_W'(in_data.read_row) * MAP_W'(COLS);
	assign rd_lin  = rd_base + MAP_W'(in_data.read_col);
	assign rd_ok   = 32'(in_data.read_row) < 32'(ROWS) && 32'(in_data.read_col) < 32'(COLS);

	// entry seen through its bank epoch: a stale tag reads as zero
	logic             sel_bank;
	logic [CNT_W-1:0] cur_cnt;
	assign sel_bank = rmw_q ? acc_sel_q : !acc_sel_q;
	assign cur_cnt  = (rd_data[sel_bank].tag == ep_q[sel_bank]) ?
		rd_data[sel_bank].count : '0;

	// bank write side
	always_comb begin
		wr_addr = addr_q;
		wr_data = '{tag: ep_q[acc_sel_q], count: cur_cnt + CNT_W'(1)};
		bank_we = 2'b00;
		if (state_q == ST_CLR) begin
			wr_addr = clr_addr_q;
			wr_data = '{tag: '0, count: '0};
			bank_we = clr_mask_q;
		end else if (state_q == ST_WAIT && rmw_q) begin
			bank_we[acc_sel_q] = 1'b1;
		end
	end

	for (genvar b = 0; b < 2; b++) begin : g_bank
		phfh_bank #(.DEPTH(DEPTH)) u_bank (
			.clk     (clk),
			.we      (bank_we[b]),
			.wr_addr (wr_addr),
			.wr_data (wr_data),
			.rd_addr (addr_q),
			.rd_data (rd_data[b])
		);
	end

	// stream registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfb_q      <= '0;
			wi_q       <= '0;
			hbn_q      <= 1'b0;
			low_q      <= '0;
			prev_q     <= '0;
			tail_q     <= 1'b0;
			row_q      <= '0;
			row_base_q <= '0;
			fill_q     <= 4'd8;
			tally_q    <= '0;
			for (int k = 0; k < 8; k++) begin
				stat_q[k] <= '0;
			end
		end else if (accept && in_data.op == OP_STREAM) begin
			lfb_q      <= lfb_n;
			wi_q       <= wi_n;
			hbn_q      <= hbn_n;
			low_q      <= low_n;
			prev_q     <= prev_n;
			tail_q     <= tail_n;
			row_q      <= row_n;
			row_base_q <= MAP_W'(row_n) * MAP_W'(COLS);
			fill_q     <= fill_n;
			for (int k = 0; k < 8; k++) begin
				stat_q[k] <= stat_n[k];
			end
			if (frame_end) begin
				tally_q <= publish ? 16'd0 : tally_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= 16'd1;
		end else if (cfg_we) begin
			frames_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			acc_sel_q   <= 1'b0;
			ep_q[0]     <= '0;
			ep_q[1]     <= '0;
			clr_mask_q  <= 2'b11;
			clr_pend_q  <= 1'b0;
			clr_addr_q  <= '0;
			addr_q      <= '0;
			run_q       <= '0;
			rmw_q       <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: loaded from emit, freed when the receiver takes it
			if (state_q == ST_EMIT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						// all tags now zero, an epoch of one marks them stale
						if (clr_mask_q[0]) ep_q[0] <= EPOCH_W'(1);
						if (clr_mask_q[1]) ep_q[1] <= EPOCH_W'(1);
						clr_addr_q <= '0;
						clr_mask_q <= 2'b00;
						state_q    <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_data.op == OP_READ) begin
							res_q      <= '{kind: KIND_PIXEL, default: '0};
							rmw_q      <= 1'b0;
							addr_q     <= rd_lin[AW-1:0];
							state_q    <= rd_ok ? ST_RD : ST_EMIT;
						end else if (frame_end) begin
							res_q.kind          <= KIND_STATUS;
							res_q.frame_number  <= {stat_n[1][3:0], stat_n[2], stat_n[3]};
							res_q.latchup_flags <= stat_n[1][5:4];
							res_q.temperature   <= stat_n[4];
							res_q.adc_channel   <= stat_n[6][3:2];
							res_q.adc_value     <= {stat_n[6][1:0], stat_n[7]};
							res_q.map_published <= publish;
							res_q.pixel_count   <= '0;
							if (publish) begin
								// swap banks; the new accumulation bank moves to a fresh epoch
								acc_sel_q <= !acc_sel_q;
								ep_q[!acc_sel_q] <= ep_q[!acc_sel_q] + EPOCH_W'(1);
								if (ep_q[!acc_sel_q] == '1) begin
									clr_pend_q <= 1'b1;
									clr_mask_q <= acc_sel_q ? 2'b01 : 2'b10;
								end
							end
							state_q <= ST_EMIT;
						end else if (hit) begin
							rmw_q   <= 1'b1;
							addr_q  <= AW'(row_base_q + MAP_W'(hit_col));
							run_q   <= hit_code;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (rmw_q) begin
						if (run_q != 2'd0) begin
							run_q   <= run_q - 2'd1;
							addr_q  <= addr_q + AW'(1);
							state_q <= ST_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						res_q.pixel_count <= cur_cnt;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						clr_pend_q  <= 1'b0;
						state_q     <= clr_pend_q ? ST_CLR : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

// ----- sv/phfh_bank.sv -----
// phfh_bank: one map bank, one write and one registered read port
// depends on phfh_pkg
`default_nettype none
module phfh_bank
	import phfh_pkg::*;
#(
	parameter int DEPTH = ROWS_DEF * COLS_DEF
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  wr_addr,
	input  wire map_entry_t          wr_data,
	input  wire [$clog2(DEPTH)-1:0]  rd_addr,
	output map_entry_t               rd_data
);
	map_entry_t mem [DEPTH];
	map_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;
endmodule
`default_nettype wire

// ----- sv/phfh_checker.sv -----
// phfh_checker: port-level assertions on the histogrammer top, bound to it
// depends on phfh_pkg and pixel_hit_frame_histogrammer_top
`default_nettype none
module phfh_checker
	import phfh_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire in_item_t  in_data,
	input wire        out_valid,
	input wire        out_stall,
	input wire out_item_t out_data
);
	// a held transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output transaction changed while stalled");

	// the clearing pass keeps input stalled straight after reset
	a_reset_clear: assert property (@(posedge clk)
		$past(!arst_n) && arst_n |-> in_stall)
		else $error("input taken during clearing pass");

	// a pixel read keeps input stalled once it is taken
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.op == OP_READ |=> in_stall)
		else $error("pixel read did not stall input");

	// some fields of a result kind that do not apply stay zero
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.kind == KIND_STATUS && out_data.pixel_count == '0) ||
		(out_data.kind == KIND_PIXEL && out_data.frame_number == '0 &&
		 out_data.map_published == 1'b0 && out_data.temperature == '0))
		else $error("unused result fields not zero");
endmodule

bind pixel_hit_frame_histogrammer_top phfh_checker u_phfh_checker (.*);
`default_nettype wire

// ----- test/tb_pixel_hit_frame_histogrammer_top.sv -----
// testbench of the pixel hit frame histogrammer: frames, hits, publishing and pixel reads
// checked against an in-bench predictor; depends on phfh_pkg and the top level
`default_nettype none
module tb_pixel_hit_frame_histogrammer_top;
	import phfh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ROWS = ROWS_DEF;
	localparam int N_COLS = COLS_DEF;
	localparam int MAX_REPORTS = 10;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_we;
	logic [15:0] cfg_data;

	pixel_hit_frame_histogrammer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// predictor state: stream decoder, status capture, publishing and both maps
	bit [31:0] byte_window;
	bit [2:0]  word_pos;
	bit        odd_byte;
	bit [7:0]  low_hold;
	bit [15:0] prev_word;
	bit        tail_pending;
	bit [9:0]  row_now;
	bit [7:0]  status_q [8];
	int        status_pos;
	bit [15:0] frames_seen;
	bit [15:0] frames_target;
	bit [15:0] hit_map [int unsigned];
	bit [15:0] shown_map [int unsigned];

	out_item_t expected_q [$];
	int        mismatches;
	int        items_sent;
	int        results_checked;
	int        frames_ended;
	int        publishes;
	bit        no_idle;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// overall time guard, allows for the clearing pass after reset
	initial begin
		#40_000_000;
		$display("Mismatches found");
		$finish;
	end

	// row word, or hit run into the accumulation map
	function automatic void decode_prev(bit [15:0] w);
		int unsigned col, code, addr;
		if (w[12]) begin
			row_now = w[11:2];
			return;
		end
		col  = w[11:2];
		code = w[1:0];
		if (col + code < N_COLS && row_now < N_ROWS) begin
			for (int j = 0; j <= code; j++) begin
				addr = row_now * N_COLS + col + j;
				if (hit_map.exists(addr)) hit_map[addr] = hit_map[addr] + 16'd1;
				else hit_map[addr] = 16'd1;
			end
		end
	endfunction

	// frame end: status transaction and possibly publish
	function automatic out_item_t close_frame();
		out_item_t r;
		r = '0;
		word_pos     = 3'd0;
		tail_pending = 1'b0;
		status_pos   = 8;
		frames_seen  = frames_seen + 16'd1;
		frames_ended++;
		r.kind = KIND_STATUS;
		if (frames_seen == frames_target) begin
			frames_seen = 16'd0;
			shown_map = hit_map;
			hit_map.delete();
			r.map_published = 1'b1;
			publishes++;
		end
		r.frame_number  = {status_q[1][3:0], status_q[2], status_q[3]};
		r.latchup_flags = status_q[1][5:4];
		r.temperature   = status_q[4];
		r.adc_channel   = status_q[6][3:2];
		r.adc_value     = {status_q[6][1:0], status_q[7]};
		return r;
	endfunction

	// works out what an accepted input transaction produces
	function automatic void predict_item(in_item_t it);
		out_item_t   r;
		bit [7:0]    b;
		bit [15:0]   w, p;
		int unsigned addr;
		r = '0;
		if (it.op == OP_READ) begin
			r.kind = KIND_PIXEL;
			if (it.read_row < N_ROWS && it.read_col < N_COLS) begin
				addr = it.read_row * N_COLS + it.read_col;
				if (shown_map.exists(addr)) r.pixel_count = shown_map[addr];
			end
			expected_q.push_back(r);
			return;
		end
		b = it.data_byte;
		byte_window = {byte_window[23:0], b};
		if (word_pos == 3'd0) begin
			if (byte_window == HEADER_WORD) begin
				word_pos   = 3'd1;
				odd_byte   = 1'b0;
				status_pos = 0;
			end
			return;
		end
		if (status_pos < 8) begin
			status_q[status_pos] = b;
			status_pos++;
		end
		if (!odd_byte) begin
			low_hold = b;
			odd_byte = 1'b1;
			return;
		end
		odd_byte  = 1'b0;
		w         = {b, low_hold};
		p         = prev_word;
		prev_word = w;
		if (word_pos < 3'd7) word_pos++;
		if (w == TAIL_WORD) begin
			if (!tail_pending) begin
				tail_pending = 1'b1;
				return;
			end
			expected_q.push_back(close_frame());
			return;
		end
		tail_pending = 1'b0;
		if (word_pos >= 3'd7) decode_prev(p);
	endfunction

	// shared sender: random gap (none under no_idle), then hold until the transaction is taken
	task automatic send_item(in_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_item(it);
		items_sent++;
	endtask

	task automatic send_byte(bit [7:0] b);
		in_item_t it;
		it = {OP_STREAM, b, 10'($urandom), 10'($urandom)};
		send_item(it);
	endtask

	task automatic send_word(bit [15:0] w);
		send_byte(w[7:0]);
		send_byte(w[15:8]);
	endtask

	task automatic send_read(bit [9:0] r, bit [9:0] c);
		in_item_t it;
		it = {OP_READ, 8'($urandom), r, c};
		send_item(it);
	endtask

	// rows and columns mostly in a small corner, so that reads find counts
	function automatic bit [9:0] pick_row();
		case ($urandom_range(0, 9))
			0:       return 10'(N_ROWS - 1);
			1:       return 10'($urandom_range(N_ROWS, 1023));
			2:       return 10'($urandom);
			default: return 10'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic bit [9:0] pick_col();
		case ($urandom_range(0, 9))
			0:       return 10'($urandom_range(N_COLS - 4, N_COLS - 1));
			1:       return 10'($urandom_range(N_COLS, 1023));
			2:       return 10'($urandom);
			default: return 10'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic bit [15:0] row_word(bit [9:0] r);
		return {3'($urandom), 1'b1, r, 2'($urandom)};
	endfunction

	function automatic bit [15:0] hit_word(bit [9:0] c, bit [1:0] code);
		return {3'($urandom), 1'b0, c, code};
	endfunction

	// header, status bytes, data words, two tails
	task automatic send_frame(int n_words);
		repeat (4) send_byte(8'haa);
		repeat (8) send_byte(8'($urandom));
		for (int i = 0; i < n_words; i++) begin
			if ($urandom_range(0, 3) == 0) send_word(row_word(pick_row()));
			else send_word(hit_word(pick_col(), 2'($urandom)));
		end
		send_word(TAIL_WORD);
		send_word(TAIL_WORD);
	endtask

	// brings the stream back to hunting after noise or a broken frame
	task automatic resync();
		if (word_pos != 3'd0) begin
			if (odd_byte) send_byte(8'($urandom));
			send_word(TAIL_WORD);
			send_word(TAIL_WORD);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		// a last hit word may still be in its read-modify-write loop
		repeat (30) @(posedge clk);
	endtask

	task automatic write_target(bit [15:0] v);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		frames_target = v;
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result transaction: %p", out_data);
			end else begin
				e = expected_q.pop_front();
				if (out_data.kind !== e.kind || out_data.frame_number !== e.frame_number
						|| out_data.latchup_flags !== e.latchup_flags
						|| out_data.temperature !== e.temperature
						|| out_data.adc_channel !== e.adc_channel
						|| out_data.adc_value !== e.adc_value
						|| out_data.map_published !== e.map_published
						|| out_data.pixel_count !== e.pixel_count) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result mismatch: expected %p, actual %p", e, out_data);
				end
			end
		end
	end

	// receiver back-pressure, one drawn hold-off per result transaction
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// extremes of fields, every op, the special cases of the framing
	task automatic test_directed();
		// reads of the empty map, corners and out of range
		send_read(10'd0, 10'd0);
		send_read(10'(N_ROWS - 1), 10'(N_COLS - 1));
		send_read(10'd1023, 10'd1023);
		// noise while hunting, then a short frame ended before all of its status bytes
		send_byte(8'hff);
		send_byte(8'h00);
		repeat (4) send_byte(8'haa);
		send_word(TAIL_WORD);
		send_word(TAIL_WORD);
		// full frame: row word, full run at the right edge, run past the edge, a last hit word
		repeat (4) send_byte(8'haa);
		send_byte(8'h00); send_byte(8'hff); send_byte(8'hff); send_byte(8'hff);
		send_byte(8'hff); send_byte(8'h00); send_byte(8'hff); send_byte(8'hff);
		send_word(row_word(10'd1));
		send_word(hit_word(10'(N_COLS - 4), 2'd3));
		send_word(hit_word(10'(N_COLS - 2), 2'd3));
		send_word(hit_word(10'd0, 2'd0));
		send_word(TAIL_WORD);
		send_word(TAIL_WORD);
		send_read(10'd1, 10'(N_COLS - 1));
		send_read(10'd1, 10'(N_COLS - 2));
	endtask

	// a lone tail gets decoded as a row word by the next word
	task automatic test_lone_tail();
		repeat (4) send_byte(8'haa);
		repeat (8) send_byte(8'($urandom));
		send_word(hit_word(10'd2, 2'd1));
		send_word(TAIL_WORD);
		send_word(hit_word(10'd3, 2'd0));
		send_word(hit_word(10'd4, 2'd2));
		send_word(TAIL_WORD);
		send_word(TAIL_WORD);
		send_read(10'h19e, 10'd4);
	endtask

	// publish period across several register settings, extremes included
	task automatic test_publish_period();
		write_target(16'd1);
		send_frame(3);
		write_target(16'd3);
		repeat (3) send_frame(2);
		write_target(16'd65535);
		repeat (2) send_frame(2);
		write_target(16'd0);
		repeat (2) send_frame(2);
		// target below the running tally: no publish until the tally wraps
		write_target(16'd1);
		send_frame(1);
		write_target(frames_seen + 16'd2);
		repeat (2) send_frame(2);
		for (int r = 0; r < 4; r++) send_read(10'(r), 10'($urandom_range(0, 7)));
	endtask

	// mostly well-formed frames with random content, some reads and noise
	task automatic test_random_stream();
		int pick;
		while (items_sent < 450) begin
			if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
			pick = $urandom_range(0, 19);
			if (pick < 13) begin
				send_frame($urandom_range(0, 6));
			end else if (pick < 17) begin
				repeat ($urandom_range(1, 4)) send_read(pick_row(), pick_col());
			end else if (pick < 19) begin
				repeat (4) send_byte(8'haa);
				repeat ($urandom_range(0, 15)) send_byte(8'($urandom));
				resync();
			end else begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
				resync();
			end
			if ($urandom_range(0, 39) == 0)
				write_target(16'($urandom_range(1, 3)));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int guard;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		byte_window   = '0;
		word_pos      = '0;
		odd_byte      = 1'b0;
		low_hold      = '0;
		prev_word     = '0;
		tail_pending  = 1'b0;
		row_now       = '0;
		status_q      = '{default: 8'd0};
		status_pos    = 8;
		frames_seen   = '0;
		frames_target = 16'd1;
		mismatches = 0; items_sent = 0; results_checked = 0;
		frames_ended = 0; publishes = 0; no_idle = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_lone_tail();
		test_publish_period();
		test_random_stream();

		// drain, with a bound
		in_valid <= 1'b0;
		guard = 0;
		while (expected_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
		if (expected_q.size() != 0) begin
			mismatches += expected_q.size();
			$display("%0d expected result transactions never arrived", expected_q.size());
		end
		$display("sent %0d input transactions, checked %0d results", items_sent,
			results_checked);
		$display("%0d frames ended, map published %0d times", frames_ended, publishes);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
`default_nettype wire
